// ===== src/mlfe_pkg.sv =====
// shared types and constants for the led fade engine
package mlfe_pkg;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] channel;
		logic       all_channels;
		logic [7:0] value;
		logic [5:0] profile_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0] out_channel;
		logic [7:0] duty;
		logic       drive_on;
		logic       fading_active;
		logic       last_result;
	} out_item_t;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_FADE    = 3'd1;
	localparam logic [2:0] OP_MANUAL  = 3'd2;
	localparam logic [2:0] OP_HOLD    = 3'd3;
	localparam logic [2:0] OP_PROFILE = 3'd4;
	localparam logic [2:0] OP_RATE    = 3'd5;

	localparam logic REG_MANUAL_STEP = 1'b0;
	localparam logic REG_RATE_UNIT   = 1'b1;

	localparam logic [15:0] MANUAL_STEP_RESET = 16'd10000;
	localparam logic [9:0]  RATE_UNIT_RESET   = 10'd100;
	localparam logic [7:0]  FADE_RATE_RESET   = 8'd10;
	localparam int          DIV_STEPS         = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_DUTY,
		ST_EMIT,
		ST_FLAG
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start_div;
		logic div_step;
		logic div_done;
		logic walk_load;
		logic walk_update;
		logic duty_calc;
		logic emit_fill;
		logic flag_fix;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic moving_ch;
		logic last_ch;
		logic buf_empty;
	} dp_stat_t;

endpackage

// ===== src/mlfe_datapath.sv =====
// per-channel state, shared divider, tick walk and profile interpolation
module mlfe_datapath #(
	parameter int CHANNELS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [15:0]         cfg_data,
	input  mlfe_pkg::in_item_t  item,
	input  logic                item_take,
	input  mlfe_pkg::dp_cmd_t   cmd,
	output mlfe_pkg::dp_stat_t  stat,
	output mlfe_pkg::out_item_t res,
	output logic                res_valid,
	input  logic                res_ready
);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DW = CW + 1;
	localparam int BW = $clog2(CHANNELS + 1);

	logic [15:0] manual_step_q;
	logic [9:0]  rate_unit_q;
	logic [23:0] level_q [CHANNELS];
	logic [24:0] step_q [CHANNELS];
	logic [7:0]  goal_q [CHANNELS];
	logic [7:0]  rate_q [CHANNELS];
	logic [CHANNELS:0] dir_q;
	logic [7:0]  prof_q [64];
	logic [63:0] prof_wr_q;

	logic [CW-1:0] div_ch_q, walk_ch_q;
	logic          div_neg_q;
	logic [23:0]   quo_q;
	logic [41:0]   rem_q;
	logic [17:0]   span_q;
	logic          moving_any_q;
	logic [7:0]    xf_q;
	logic [7:0]    p1_q, p2_q;
	logic [7:0]    duty_q;
	mlfe_pkg::out_item_t buf_q [CHANNELS];
	logic [BW-1:0] wr_cnt_q, rd_cnt_q;

	logic ch_ok;
	assign ch_ok = {29'd0, item.channel} < 32'(CHANNELS);
	logic [CW-1:0] in_ch;
	assign in_ch = CW'(item.channel);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_step_q <= mlfe_pkg::MANUAL_STEP_RESET;
			rate_unit_q   <= mlfe_pkg::RATE_UNIT_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == mlfe_pkg::REG_MANUAL_STEP) manual_step_q <= cfg_data;
			else rate_unit_q <= cfg_data[9:0];
		end
	end

	// walk-channel step arithmetic
	logic [24:0] cur_step;
	logic [23:0] cur_lvl;
	logic [7:0]  cur_goal;
	logic signed [26:0] sum;
	logic arrive;
	assign cur_step = step_q[walk_ch_q];
	assign cur_lvl  = level_q[walk_ch_q];
	assign cur_goal = goal_q[walk_ch_q];
	assign sum = $signed({3'b000, cur_lvl}) + $signed({{2{cur_step[24]}}, cur_step});
	always_comb begin
		if (!cur_step[24]) arrive = $signed(sum[26:16]) >= $signed({3'b000, cur_goal});
		else arrive = sum[26] || ($signed(sum[26:16]) <= $signed({3'b000, cur_goal}));
	end
	assign stat.moving_ch = cur_step != '0;
	assign stat.last_ch   = (DW'(walk_ch_q) == DW'(CHANNELS - 1));

	// divider trial subtract
	logic [42:0] trial;
	assign trial = {rem_q, quo_q[23]} - {25'd0, span_q};

	logic [7:0] cur_int_div;
	assign cur_int_div = level_q[div_ch_q][23:16];

	// per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				level_q[i] <= '0;
				step_q[i]  <= '0;
				goal_q[i]  <= '0;
				rate_q[i]  <= mlfe_pkg::FADE_RATE_RESET;
			end
			dir_q        <= '0;
			walk_ch_q    <= '0;
			div_ch_q     <= '0;
			div_neg_q    <= 1'b0;
			moving_any_q <= 1'b0;
		end else begin
			if (item_take) begin
				case (item.op)
					mlfe_pkg::OP_FADE: begin
						if (ch_ok) begin
							goal_q[in_ch] <= item.value;
							div_ch_q <= in_ch;
						end
					end
					mlfe_pkg::OP_MANUAL: begin
						if (item.all_channels) begin
							dir_q[CHANNELS] <= ~dir_q[CHANNELS];
							for (int i = 0; i < CHANNELS; i++) begin
								goal_q[i] <= dir_q[CHANNELS] ? 8'd0 : 8'd255;
								step_q[i] <= dir_q[CHANNELS] ? -{9'd0, manual_step_q}
									: {9'd0, manual_step_q};
							end
						end else if (ch_ok) begin
							dir_q[in_ch] <= ~dir_q[in_ch];
							goal_q[in_ch] <= dir_q[in_ch] ? 8'd0 : 8'd255;
							step_q[in_ch] <= dir_q[in_ch] ? -{9'd0, manual_step_q}
								: {9'd0, manual_step_q};
						end
					end
					mlfe_pkg::OP_HOLD: begin
						for (int i = 0; i < CHANNELS; i++) begin
							if (item.all_channels || (ch_ok && in_ch == CW'(i))) begin
								goal_q[i] <= level_q[i][23:16];
								step_q[i] <= '0;
							end
						end
					end
					mlfe_pkg::OP_RATE: if (ch_ok) rate_q[in_ch] <= item.value;
					default: ;
				endcase
			end
			if (cmd.start_div) div_neg_q <= goal_q[div_ch_q] < cur_int_div;
			if (cmd.div_done)
				step_q[div_ch_q] <= div_neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
			if (cmd.walk_load) begin
				walk_ch_q    <= '0;
				moving_any_q <= 1'b0;
			end
			if (cmd.walk_update) begin
				if (cur_step != '0) begin
					if (arrive) begin
						level_q[walk_ch_q] <= {cur_goal, 16'd0};
						step_q[walk_ch_q]  <= '0;
					end else begin
						level_q[walk_ch_q] <= sum[23:0];
						moving_any_q <= 1'b1;
					end
				end
				if (!stat.last_ch) walk_ch_q <= walk_ch_q + CW'(1);
			end
		end
	end

	// divider: restoring, one quotient bit per cycle
	logic [7:0] rate_eff;
	logic [9:0] unit_eff;
	logic [7:0] delta;
	assign rate_eff = (rate_q[div_ch_q] == 8'd0) ? 8'd1 : rate_q[div_ch_q];
	assign unit_eff = (rate_unit_q == 10'd0) ? 10'd1 : rate_unit_q;
	assign delta = (goal_q[div_ch_q] < cur_int_div) ? cur_int_div - goal_q[div_ch_q]
		: goal_q[div_ch_q] - cur_int_div;
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			span_q <= 18'(rate_eff * unit_eff);
			quo_q  <= {delta, 16'd0};
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			if (!trial[42]) begin
				rem_q <= trial[41:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= {rem_q[40:0], quo_q[23]};
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	// profile table, written points tracked by flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prof_wr_q <= '0;
		else if (item_take && item.op == mlfe_pkg::OP_PROFILE)
			prof_wr_q[item.profile_index] <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (item_take && item.op == mlfe_pkg::OP_PROFILE)
			prof_q[item.profile_index] <= item.value;
	end

	// fetch profile points and fraction for the new level
	logic [23:0] lvl_next;
	logic [5:0]  nxi, nxi1;
	assign lvl_next = (cur_step != '0 && !arrive) ? sum[23:0] : {cur_goal, 16'd0};
	assign nxi  = lvl_next[23:18];
	assign nxi1 = (nxi == 6'd63) ? nxi : nxi + 6'd1;
	always_ff @(posedge clk) begin
		if (cmd.walk_update) begin
			xf_q <= lvl_next[17:10];
			p1_q <= prof_wr_q[nxi]  ? prof_q[nxi]  : {nxi, 2'b00};
			p2_q <= prof_wr_q[nxi1] ? prof_q[nxi1] : {nxi1, 2'b00};
		end
	end

	logic [15:0] r;
	always_comb begin
		if (p2_q > p1_q) r = {p1_q, 8'd0} + 16'((p2_q - p1_q) * xf_q);
		else r = {p1_q, 8'd0} - 16'((p1_q - p2_q) * xf_q);
	end
	always_ff @(posedge clk) begin
		if (cmd.duty_calc) duty_q <= r[15:8];
	end

	// result buffer for one tick
	logic [CW-1:0] emit_ch_q;
	always_ff @(posedge clk) begin
		if (cmd.walk_update) emit_ch_q <= walk_ch_q;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit_fill) begin
			buf_q[wr_cnt_q[CW-1:0]] <= '{out_channel: 3'(emit_ch_q), duty: duty_q,
				drive_on: duty_q != 8'd0, fading_active: 1'b0, last_result: 1'b0};
		end
		if (cmd.flag_fix) begin
			for (int i = 0; i < CHANNELS; i++) begin
				buf_q[i].fading_active <= moving_any_q;
				buf_q[i].last_result   <= (BW'(i) == wr_cnt_q - BW'(1));
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q <= '0;
			rd_cnt_q <= '0;
		end else begin
			if (cmd.walk_load) begin
				wr_cnt_q <= '0;
				rd_cnt_q <= '0;
			end
			if (cmd.emit_fill) wr_cnt_q <= wr_cnt_q + BW'(1);
			if (res_valid && res_ready) rd_cnt_q <= rd_cnt_q + BW'(1);
		end
	end
	logic out_ok_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ok_q <= 1'b0;
		else if (cmd.walk_load) out_ok_q <= 1'b0;
		else if (cmd.flag_fix) out_ok_q <= 1'b1;
	end
	assign res_valid = out_ok_q && (rd_cnt_q != wr_cnt_q);
	assign res = buf_q[rd_cnt_q[CW-1:0]];
	assign stat.buf_empty = !res_valid;

endmodule

// ===== src/mlfe_ctrl.sv =====
// controller state machine sequencing commands and ticks
module mlfe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2:0]         in_op,
	input  logic               ch_ok,
	output logic               in_ready,
	output mlfe_pkg::dp_cmd_t  cmd,
	input  mlfe_pkg::dp_stat_t stat
);
	mlfe_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic       moved_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mlfe_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// divide cycle counter, runs while dividing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (state_q == mlfe_pkg::ST_DIV) cnt_q <= cnt_q + 5'd1;
		else cnt_q <= '0;
	end

	// remembers whether current walk channel emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) moved_q <= 1'b0;
		else if (cmd.walk_update) moved_q <= stat.moving_ch;
	end
	logic last_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_q <= 1'b0;
		else if (cmd.walk_update) last_q <= stat.last_ch;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mlfe_pkg::ST_IDLE: begin
				in_ready = stat.buf_empty;
				if (in_valid && stat.buf_empty) begin
					if (in_op == mlfe_pkg::OP_TICK) begin
						cmd.walk_load = 1'b1;
						state_d = mlfe_pkg::ST_WALK;
					end else if (in_op == mlfe_pkg::OP_FADE && ch_ok) begin
						state_d = mlfe_pkg::ST_DIV;
					end
				end
			end
			// load, one step per cycle, then write the step back
			mlfe_pkg::ST_DIV: begin
				if (cnt_q == 5'd0) begin
					cmd.start_div = 1'b1;
				end else if (cnt_q == 5'(mlfe_pkg::DIV_STEPS + 1)) begin
					cmd.div_done = 1'b1;
					state_d = mlfe_pkg::ST_IDLE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			mlfe_pkg::ST_WALK: begin
				cmd.walk_update = 1'b1;
				state_d = mlfe_pkg::ST_DUTY;
			end
			mlfe_pkg::ST_DUTY: begin
				cmd.duty_calc = 1'b1;
				state_d = mlfe_pkg::ST_EMIT;
			end
			mlfe_pkg::ST_EMIT: begin
				cmd.emit_fill = moved_q;
				state_d = last_q ? mlfe_pkg::ST_FLAG : mlfe_pkg::ST_WALK;
			end
			mlfe_pkg::ST_FLAG: begin
				cmd.flag_fix = 1'b1;
				state_d = mlfe_pkg::ST_IDLE;
			end
			default: state_d = mlfe_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== src/multichannel_led_fade_engine_top.sv =====
// top level: six-channel led fade engine
// a tick walks all channels through the walk, duty and emit states in turn, then
// its results drain at one beat per cycle while out_ready is high; a fade command
// runs in the shared restoring divider before the next item is taken, other commands complete in idle.
// one item at a time; input is held off until the previous tick's beats drain.
// arst_n clears all channel state, config registers and the profile to defaults.
module multichannel_led_fade_engine_top #(
	parameter int CHANNELS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mlfe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mlfe_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [15:0]         cfg_data
);
	mlfe_pkg::dp_cmd_t  cmd;
	mlfe_pkg::dp_stat_t stat;
	logic ch_ok;
	assign ch_ok = 32'(in_data.channel) < CHANNELS;

	mlfe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_op(in_data.op),
		.ch_ok(ch_ok), .in_ready(in_ready),
		.cmd(cmd), .stat(stat)
	);

	mlfe_datapath #(.CHANNELS(CHANNELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .item(in_data), .item_take(in_valid && in_ready),
		.cmd(cmd), .stat(stat), .res(out_data), .res_valid(out_valid),
		.res_ready(out_ready)
	);

endmodule

// ===== verif/multichannel_led_fade_engine_top_tb.sv =====
// testbench for the six-channel led fade engine: directed and random commands against a model
module multichannel_led_fade_engine_top_tb;

	localparam int NCH       = 6;
	localparam int CYC_LIMIT = 400000;
	localparam int SETTLE    = 48;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	mlfe_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	mlfe_pkg::out_item_t out_data;
	logic      cfg_we;
	logic      cfg_idx;
	logic [15:0] cfg_data;

	multichannel_led_fade_engine_top #(.CHANNELS(NCH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// model state
	logic [15:0]      m_manual_step;
	logic [9:0]       m_rate_unit;
	logic [23:0]      m_level [NCH];
	int               m_step [NCH];
	logic [7:0]       m_goal [NCH];
	logic [7:0]       m_rate [NCH];
	logic             m_dir [NCH+1];
	logic [7:0]       m_profile [64];
	mlfe_pkg::out_item_t duty_expect [$];

	int  cycles;
	int  errors;
	int  items_sent;
	int  beats_seen;
	int  hold_req;
	bit  rx_steady;

	// clock and cycle limit
	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats pending", cycles, duty_expect.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [7:0] profile_map(logic [23:0] lvl);
		int unsigned x, xi, xf, p1, p2, r;
		x  = lvl[23:8] >> 2;
		xi = (x >> 8) & 63;
		xf = x & 255;
		p1 = m_profile[xi];
		p2 = (xi < 63) ? m_profile[xi+1] : p1;
		if (p2 > p1)
			r = (p1 << 8) + (p2 - p1) * xf;
		else
			r = (p1 << 8) - (p1 - p2) * xf;
		return r[15:8];
	endfunction

	task automatic set_ramp(int c, bit up);
		m_goal[c] = up ? 8'd255 : 8'd0;
		m_step[c] = up ? int'(m_manual_step) : -int'(m_manual_step);
	endtask

	// advance the model by one accepted beat
	task automatic fade_predict(mlfe_pkg::in_item_t it);
		bit moving;
		bit ok;
		longint sum;
		int unsigned span, cur, rt, un;
		mlfe_pkg::out_item_t r;
		int first;
		moving = 0;
		ok = it.channel < NCH;
		first = duty_expect.size();
		case (it.op)
			mlfe_pkg::OP_TICK: begin
				for (int i = 0; i < NCH; i++) begin
					if (m_step[i] == 0)
						continue;
					sum = longint'(m_level[i]) + longint'(m_step[i]);
					if ((m_step[i] > 0 && (sum >>> 16) >= m_goal[i]) ||
					    (m_step[i] < 0 && (sum < 0 || (sum >>> 16) <= m_goal[i]))) begin
						m_level[i] = {m_goal[i], 16'h0};
						m_step[i] = 0;
					end else begin
						m_level[i] = sum[23:0];
						moving = 1;
					end
					r.out_channel   = i[2:0];
					r.duty          = profile_map(m_level[i]);
					r.drive_on      = r.duty != 0;
					r.fading_active = 0;
					r.last_result   = 0;
					duty_expect.push_back(r);
				end
				for (int k = first; k < duty_expect.size(); k++)
					duty_expect[k].fading_active = moving;
				if (duty_expect.size() > first)
					duty_expect[duty_expect.size()-1].last_result = 1;
			end
			mlfe_pkg::OP_FADE: if (ok) begin
				m_goal[it.channel] = it.value;
				rt = m_rate[it.channel] ? m_rate[it.channel] : 1;
				un = m_rate_unit ? m_rate_unit : 1;
				span = rt * un;
				cur = m_level[it.channel][23:16];
				if (it.value >= cur)
					m_step[it.channel] = int'(((it.value - cur) << 16) / span);
				else
					m_step[it.channel] = -int'(((cur - it.value) << 16) / span);
			end
			mlfe_pkg::OP_MANUAL: begin
				if (it.all_channels) begin
					m_dir[NCH] ^= 1'b1;
					for (int i = 0; i < NCH; i++)
						set_ramp(i, m_dir[NCH]);
				end else if (ok) begin
					m_dir[it.channel] ^= 1'b1;
					set_ramp(it.channel, m_dir[it.channel]);
				end
			end
			mlfe_pkg::OP_HOLD: begin
				for (int i = 0; i < NCH; i++)
					if (it.all_channels || (ok && i == it.channel)) begin
						m_goal[i] = m_level[i][23:16];
						m_step[i] = 0;
					end
			end
			mlfe_pkg::OP_PROFILE: m_profile[it.profile_index] = it.value;
			mlfe_pkg::OP_RATE: if (ok) m_rate[it.channel] = it.value;
			default: ;
		endcase
	endtask

	// offer one beat; valid stays up from a previous beat when no gap is drawn
	task automatic send_beat(mlfe_pkg::in_item_t it);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fade_predict(it);
		items_sent++;
	endtask

	function automatic mlfe_pkg::in_item_t mk(logic [2:0] op, logic [2:0] ch, logic all,
	                                          logic [7:0] v, logic [5:0] pi);
		mlfe_pkg::in_item_t it;
		it.op = op; it.channel = ch; it.all_channels = all;
		it.value = v; it.profile_index = pi;
		return it;
	endfunction

	// drop valid, let all results drain and the divider finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (duty_expect.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mlfe_pkg::REG_MANUAL_STEP)
			m_manual_step = val;
		else
			m_rate_unit = val[9:0];
	endtask

	// result checker
	always @(posedge clk) begin
		mlfe_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (duty_expect.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat ch=%0d duty=%0d", out_data.out_channel,
					         out_data.duty);
			end else begin
				want = duty_expect.pop_front();
				if (out_data !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp %0d/%0d/%0b/%0b/%0b got %0d/%0d/%0b/%0b/%0b",
						         want.out_channel, want.duty, want.drive_on,
						         want.fading_active, want.last_result,
						         out_data.out_channel, out_data.duty, out_data.drive_on,
						         out_data.fading_active, out_data.last_result);
				end
			end
		end
	end

	// receiver: random stalls per beat, with an optional long hold-off
	initial begin
		int gap;
		int held;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				out_ready <= 1'b0;
				held = 0;
				while (held < hold_req) begin
					@(posedge clk);
					held++;
				end
				hold_req = 0;
				out_ready <= 1'b1;
			end else if (out_valid && out_ready && !rx_steady) begin
				gap = $urandom_range(0, 4);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	// directed cases
	task automatic test_reset_state();
		send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
		send_beat(mk(mlfe_pkg::OP_RATE, 0, 0, 8'd0, 0));
		send_beat(mk(mlfe_pkg::OP_FADE, 0, 0, 8'd255, 0));
		send_beat(mk(mlfe_pkg::OP_RATE, 5, 0, 8'd255, 0));
		send_beat(mk(mlfe_pkg::OP_FADE, 5, 0, 8'd128, 0));
		repeat (3) send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
	endtask

	task automatic test_profile_edges();
		send_beat(mk(mlfe_pkg::OP_PROFILE, 0, 0, 8'd255, 6'd63));
		send_beat(mk(mlfe_pkg::OP_PROFILE, 0, 0, 8'd0, 6'd62));
		send_beat(mk(mlfe_pkg::OP_PROFILE, 0, 0, 8'd200, 6'd0));
		send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
	endtask

	task automatic test_manual_and_hold();
		send_beat(mk(mlfe_pkg::OP_MANUAL, 2, 0, 0, 0));
		send_beat(mk(mlfe_pkg::OP_MANUAL, 3'd0, 1, 0, 0));
		send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
		send_beat(mk(mlfe_pkg::OP_HOLD, 2, 0, 0, 0));
		send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
		send_beat(mk(mlfe_pkg::OP_HOLD, 7, 1, 0, 0));
		send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
	endtask

	task automatic test_ignored();
		send_beat(mk(mlfe_pkg::OP_FADE, 6, 0, 8'd99, 0));
		send_beat(mk(mlfe_pkg::OP_MANUAL, 7, 0, 0, 0));
		send_beat(mk(mlfe_pkg::OP_RATE, 6, 0, 8'd3, 0));
		send_beat(mk(OP_SPARE_A, 1, 1, 8'hff, 6'h3f));
		send_beat(mk(OP_SPARE_B, 0, 0, 0, 0));
		send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
	endtask

	// fade-then-tick and manual-then-tick sequences with random content, plus noise
	task automatic test_random_phase(int count);
		int n;
		int sel;
		mlfe_pkg::in_item_t it;
		n = 0;
		while (n < count) begin
			sel = $urandom_range(0, 99);
			it = mlfe_pkg::in_item_t'($urandom);
			if (sel < 20) begin
				it.op = mlfe_pkg::OP_FADE;
				it.channel = 3'($urandom_range(0, NCH - 1));
				send_beat(it);
				repeat ($urandom_range(2, 6)) begin
					send_beat(mk(mlfe_pkg::OP_TICK, 3'($urandom), 1'($urandom),
					             8'($urandom), 6'($urandom)));
					n++;
				end
			end else if (sel < 30) begin
				it.op = mlfe_pkg::OP_MANUAL;
				send_beat(it);
				repeat ($urandom_range(2, 5)) begin
					send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
					n++;
				end
			end else if (sel < 55) begin
				it.op = mlfe_pkg::OP_TICK;
				send_beat(it);
			end else if (sel < 62) begin
				it.op = mlfe_pkg::OP_HOLD;
				send_beat(it);
			end else if (sel < 72) begin
				it.op = mlfe_pkg::OP_PROFILE;
				send_beat(it);
			end else if (sel < 84) begin
				it.op = mlfe_pkg::OP_RATE;
				if ($urandom_range(0, 3) != 0) it.value = 8'($urandom_range(0, 3));
				send_beat(it);
			end else begin
				send_beat(it);
			end
			n++;
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		send_beat(mk(mlfe_pkg::OP_MANUAL, 0, 1, 0, 0));
		hold_req = 300;
		repeat (12) send_beat(mk(mlfe_pkg::OP_TICK, 0, 0, 0, 0));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = mlfe_pkg::REG_MANUAL_STEP;
		cfg_data = '0;
		cycles = 0;
		errors = 0;
		items_sent = 0;
		beats_seen = 0;
		hold_req = 0;
		rx_steady = 0;
		m_manual_step = mlfe_pkg::MANUAL_STEP_RESET;
		m_rate_unit = mlfe_pkg::RATE_UNIT_RESET;
		for (int i = 0; i < NCH; i++) begin
			m_level[i] = '0; m_step[i] = 0; m_goal[i] = '0;
			m_rate[i] = mlfe_pkg::FADE_RATE_RESET;
		end
		for (int i = 0; i <= NCH; i++) m_dir[i] = 0;
		for (int i = 0; i < 64; i++) m_profile[i] = 8'(4 * i);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_profile_edges();
		test_manual_and_hold();
		test_ignored();

		write_reg(mlfe_pkg::REG_MANUAL_STEP, 16'd65535);
		write_reg(mlfe_pkg::REG_RATE_UNIT, 16'd1);
		test_random_phase(80);
		write_reg(mlfe_pkg::REG_MANUAL_STEP, 16'd1);
		write_reg(mlfe_pkg::REG_RATE_UNIT, 16'd1000);
		rx_steady = 1;
		test_random_phase(60);
		rx_steady = 0;
		test_backpressure();
		write_reg(mlfe_pkg::REG_MANUAL_STEP, 16'($urandom_range(1, 65535)));
		write_reg(mlfe_pkg::REG_RATE_UNIT, 16'($urandom_range(1, 1000)));
		test_random_phase(80);
		write_reg(mlfe_pkg::REG_MANUAL_STEP, mlfe_pkg::MANUAL_STEP_RESET);
		write_reg(mlfe_pkg::REG_RATE_UNIT, 16'($urandom_range(1, 20)));
		test_random_phase(80);

		wait_idle();
		$display("run covered %0d commands and %0d duty beats over %0d cycles",
		         items_sent, beats_seen, cycles);
		$display("fades, ramps, holds, profile and rate writes, four register settings");
		if (errors == 0 && duty_expect.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
